// ----- rtl/core/ssps_pkg.sv -----
package ssps_pkg;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_CLOSE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    // item modes
    localparam logic MODE_PROPOSE = 1'b0;
    localparam logic MODE_READ    = 1'b1;

    // configuration register indexes
    localparam logic CFG_MIN_SPACING  = 1'b0;
    localparam logic CFG_TARGET_COUNT = 1'b1;

    typedef struct packed {
        logic [31:0] min_spacing;
        logic [8:0]  target_count;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  stored_count;
        logic [31:0] entry_value;
    } t_result;

endpackage

// ----- rtl/core/spaced_sorted_position_set.sv -----
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+-------------------------------------------
// input    | i_in_valid   | o_in_stall   | i_mode, i_position, i_read_index
// output   | o_out_valid  | i_out_stall  | o_status, o_stored_count, o_entry_value
// config   | i_cfg_we     | -            | i_cfg_index, i_cfg_data
//
// one word at a time; a read passes through S_READ, a proposal refused as full goes straight to S_DONE
// a proposal binary-searches the position memory, a read and a compare per probe, p probes, about log2(n)
// a too-close proposal ends after the search; an accepted one moves every entry above it up
// one slot, one memory word per cycle, read and written through the separate ports, then is stored
// synchronous active-low reset empties the table and loads min_spacing 100, target 256
// a finished word waits in the output register; the next word is taken meanwhile
module spaced_sorted_position_set #(
    parameter int CAPACITY = 256,
    parameter int POS_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [31:0] i_position,
    input  logic [7:0]  i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [8:0]  o_stored_count,
    output logic [31:0] o_entry_value
);

    import ssps_pkg::*;

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;

    logic    seq_idle;
    logic    seq_done;
    logic    in_take;
    logic    out_load;
    t_result seq_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_spacing  <= 32'd100;
            r_cfg.target_count <= 9'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_SPACING:  r_cfg.min_spacing  <= i_cfg_data;
                CFG_TARGET_COUNT: r_cfg.target_count <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = !seq_idle;
    assign in_take    = i_in_valid && seq_idle;
    assign out_load   = seq_done && (!r_out_valid || !i_out_stall);

    ssps_seq #(
        .CAPACITY(CAPACITY),
        .POS_BITS(POS_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (in_take),
        .i_mode      (i_mode),
        .i_position  (i_position[POS_BITS-1:0]),
        .i_read_index(i_read_index),
        .o_idle      (seq_idle),
        .o_done      (seq_done),
        .i_ack       (out_load),
        .o_result    (seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= seq_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_stored_count = r_out.stored_count;
    assign o_entry_value  = r_out.entry_value;

endmodule

// ----- rtl/core/ssps_ram.sv -----
module ssps_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ssps_seq.sv -----
module ssps_seq #(
    parameter int CAPACITY = 256,
    parameter int POS_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssps_pkg::t_cfg    i_cfg,
    input  logic              i_start,
    input  logic              i_mode,
    input  logic [POS_BITS-1:0] i_position,
    input  logic [7:0]        i_read_index,
    output logic              o_idle,
    output logic              o_done,
    input  logic              i_ack,
    output ssps_pkg::t_result o_result
);

    import ssps_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [31:0] CAP_W = 32'(CAPACITY);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SRCH_RD  = 7'b0000010,
        S_SRCH_CMP = 7'b0000100,
        S_SHIFT    = 7'b0001000,
        S_PUT      = 7'b0010000,
        S_READ     = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [POS_BITS-1:0] r_p, n_p;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic [AW-1:0]       r_mid, n_mid;
    logic [POS_BITS-1:0] r_lo_val, n_lo_val;
    logic                r_lo_v, n_lo_v;
    logic [POS_BITS-1:0] r_up_val, n_up_val;
    logic                r_up_v, n_up_v;
    logic [CW-1:0]       r_k, n_k;
    logic [AW-1:0]       r_wdst, n_wdst;
    logic                r_pend, n_pend;
    logic [1:0]          r_status, n_status;
    logic [31:0]         r_value, n_value;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [POS_BITS-1:0] ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [POS_BITS-1:0] ram_rdata;

    logic [31:0]         count_w;
    logic [31:0]         idx_w;
    logic [CW:0]         mid_sum;
    logic [CW-1:0]       k_dec;
    logic [CW-1:0]       count_inc;
    logic [31:0]         d_lo;
    logic [31:0]         d_up;
    logic                spacing_ok;

    ssps_ram #(
        .DEPTH(CAPACITY),
        .WIDTH(POS_BITS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign count_w   = 32'(r_count);
    assign idx_w     = 32'(i_read_index);
    assign mid_sum   = ({1'b0, r_lo} + {1'b0, r_hi}) >> 1;
    assign k_dec     = r_k - CW'(1);
    assign count_inc = r_count + CW'(1);

    // distances to the neighbors found by the search
    assign d_lo = 32'(r_p) - 32'(r_lo_val);
    assign d_up = 32'(r_up_val) - 32'(r_p);
    assign spacing_ok = !(r_lo_v && (d_lo < i_cfg.min_spacing)) &&
                        !(r_up_v && (d_up < i_cfg.min_spacing));

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_p      = r_p;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_lo_val = r_lo_val;
        n_lo_v   = r_lo_v;
        n_up_val = r_up_val;
        n_up_v   = r_up_v;
        n_k      = r_k;
        n_wdst   = r_wdst;
        n_pend   = r_pend;
        n_status = r_status;
        n_value  = r_value;

        ram_we    = 1'b0;
        ram_waddr = r_wdst;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_mid;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_p     = i_position;
                    n_value = 32'd0;
                    n_status = ST_OK;
                    if (i_mode == MODE_READ) begin
                        if (idx_w < count_w) begin
                            ram_re    = 1'b1;
                            ram_raddr = idx_w[AW-1:0];
                            n_state   = S_READ;
                        end else begin
                            n_status = ST_BAD_INDEX;
                            n_state  = S_DONE;
                        end
                    end else if (count_w >= CAP_W ||
                                 count_w >= 32'(i_cfg.target_count)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_lo    = '0;
                        n_hi    = r_count;
                        n_lo_v  = 1'b0;
                        n_up_v  = 1'b0;
                        n_state = S_SRCH_RD;
                    end
                end
            end
            S_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    n_mid     = mid_sum[AW-1:0];
                    ram_re    = 1'b1;
                    ram_raddr = mid_sum[AW-1:0];
                    n_state   = S_SRCH_CMP;
                end else if (!spacing_ok) begin
                    n_status = ST_TOO_CLOSE;
                    n_state  = S_DONE;
                end else begin
                    n_k     = r_count;
                    n_pend  = 1'b0;
                    n_state = S_SHIFT;
                end
            end
            S_SRCH_CMP: begin
                // last entry above p is the upper neighbor, last one not above the lower
                if (ram_rdata > r_p) begin
                    n_hi     = CW'(r_mid);
                    n_up_val = ram_rdata;
                    n_up_v   = 1'b1;
                end else begin
                    n_lo     = CW'(r_mid) + CW'(1);
                    n_lo_val = ram_rdata;
                    n_lo_v   = 1'b1;
                end
                n_state = S_SRCH_RD;
            end
            S_SHIFT: begin
                // read k-1 while the word read last cycle lands one slot higher
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wdst;
                    ram_wdata = ram_rdata;
                end
                if (r_k > r_lo) begin
                    ram_re    = 1'b1;
                    ram_raddr = k_dec[AW-1:0];
                    n_wdst    = r_k[AW-1:0];
                    n_pend    = 1'b1;
                    n_k       = k_dec;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_lo[AW-1:0];
                ram_wdata = r_p;
                n_count   = count_inc;
                n_state   = S_DONE;
            end
            S_READ: begin
                n_value = 32'(ram_rdata);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p      <= n_p;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_lo_val <= n_lo_val;
        r_lo_v   <= n_lo_v;
        r_up_val <= n_up_val;
        r_up_v   <= n_up_v;
        r_k      <= n_k;
        r_wdst   <= n_wdst;
        r_status <= n_status;
        r_value  <= n_value;
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);

    assign o_result.status       = r_status;
    assign o_result.stored_count = count_w[8:0];
    assign o_result.entry_value  = r_value;

endmodule

// ----- dv/spaced_sorted_position_set_tb.sv -----
module spaced_sorted_position_set_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssps_pkg::*;

    localparam int CAPACITY       = 256;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 300;

    // table of held positions and the results it owes, in order
    class position_table_sb;
        logic [31:0] held_pos [CAPACITY];
        int          held_count;
        logic [31:0] min_gap;
        int          target_limit;
        t_result     due_results [$];
        int          errors;

        function new();
            held_count   = 0;
            min_gap      = 32'd100;
            target_limit = 256;
            errors       = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] data);
            if (idx == CFG_MIN_SPACING) begin
                min_gap = data;
            end else begin
                target_limit = int'(data[8:0]);
            end
        endfunction

        function void take_word(logic mode, logic [31:0] pos, logic [7:0] idx);
            t_result r;
            int      slot;
            bit      spaced;
            r.status      = ST_OK;
            r.entry_value = '0;
            if (mode == MODE_READ) begin
                if (idx < held_count) begin
                    r.entry_value = held_pos[idx];
                end else begin
                    r.status = ST_BAD_INDEX;
                end
            end else if (held_count >= CAPACITY || held_count >= target_limit) begin
                r.status = ST_FULL;
            end else begin
                // equal entries stay below the new one
                slot = 0;
                while (slot < held_count && held_pos[slot] <= pos) slot++;
                spaced = 1'b1;
                if (slot > 0 && (pos - held_pos[slot-1]) < min_gap) spaced = 1'b0;
                if (slot < held_count && (held_pos[slot] - pos) < min_gap) spaced = 1'b0;
                if (!spaced) begin
                    r.status = ST_TOO_CLOSE;
                end else begin
                    for (int k = held_count; k > slot; k--) held_pos[k] = held_pos[k-1];
                    held_pos[slot] = pos;
                    held_count++;
                end
            end
            r.stored_count = held_count[8:0];
            due_results.push_back(r);
        endfunction

        function void match_result(logic [1:0] st, logic [8:0] cnt, logic [31:0] val);
            t_result w;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: expected none,", $time,
                         " got status %0d count %0d value %h", st, cnt, val);
                return;
            end
            w = due_results.pop_front();
            if (st !== w.status || cnt !== w.stored_count || val !== w.entry_value) begin
                errors++;
                $display("%0t: mismatch: expected status %0d count %0d value %h,", $time,
                         w.status, w.stored_count, w.entry_value,
                         " got status %0d count %0d value %h", st, cnt, val);
            end
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic        i_cfg_index  = 1'b0;
    logic [31:0] i_cfg_data   = '0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic        i_mode       = 1'b0;
    logic [31:0] i_position   = '0;
    logic [7:0]  i_read_index = '0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [1:0]  o_status;
    logic [8:0]  o_stored_count;
    logic [31:0] o_entry_value;

    position_table_sb sb;
    int calm_left   = 0;
    int stall_left  = 0;
    int idle_cycles = 0;

    spaced_sorted_position_set #(
        .CAPACITY(CAPACITY),
        .POS_BITS(32)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_read_index  (i_read_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_stored_count(o_stored_count),
        .o_entry_value (o_entry_value)
    );

    always #6 i_clk = ~i_clk;

    // calm stretches: no gaps and no stalls on either side
    always @(posedge i_clk) begin
        if (calm_left != 0) begin
            calm_left <= calm_left - 1;
        end else if ($urandom_range(0, 299) == 0) begin
            calm_left <= $urandom_range(50, 200);
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm_left != 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: check accepted words, stall at random
    always @(posedge i_clk) begin
        int n;
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.match_result(o_status, o_stored_count, o_entry_value);
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            n = pick_gap();
            i_out_stall <= (n > 0);
            stall_left  <= (n > 0) ? n - 1 : 0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(logic mode, logic [31:0] pos, logic [7:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_position   <= pos;
        i_read_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_word(mode, pos, idx);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic random_word(int read_pct);
        logic [31:0] pos;
        logic [31:0] base;
        logic [31:0] reach;
        logic [7:0]  idx;
        int          r;
        if ($urandom_range(0, 99) < read_pct) begin
            if (sb.held_count > 0 && $urandom_range(0, 4) != 0)
                idx = 8'($urandom_range(0, sb.held_count - 1));
            else
                idx = 8'($urandom_range(0, 255));
            send_word(MODE_READ, $urandom(), idx);
        end else begin
            base  = (sb.held_count > 0) ? sb.held_pos[$urandom_range(0, sb.held_count - 1)]
                                        : $urandom();
            reach = (sb.min_gap > 32'h0010_0000) ? 32'h0010_0000 : sb.min_gap;
            r = $urandom_range(0, 99);
            if (r < 50) begin
                pos = $urandom();
            end else if (r < 78) begin
                // near a held entry, on either side
                pos = base + $urandom_range(0, 2 * reach + 2) - reach - 1;
            end else if (r < 86) begin
                pos = base;
            end else if (r < 90) begin
                pos = base + sb.min_gap - $urandom_range(0, 1);
            end else if (r < 94) begin
                pos = base - sb.min_gap + $urandom_range(0, 1);
            end else begin
                pos = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            end
            send_word(MODE_PROPOSE, pos, 8'($urandom()));
        end
    endtask

    function automatic logic [8:0] next_target(int step);
        return 9'((sb.held_count + step > CAPACITY) ? CAPACITY : sb.held_count + step);
    endfunction

    task automatic run_phase(logic [31:0] spacing, logic [8:0] tgt, int items, int read_pct,
                             bit to_full);
        int n;
        settle();
        write_reg(CFG_MIN_SPACING, spacing);
        write_reg(CFG_TARGET_COUNT, ($urandom() & 32'hFFFF_FE00) | tgt);
        n = 0;
        if (to_full) begin
            while (sb.held_count < CAPACITY && n < 1000) begin
                random_word(read_pct);
                n++;
            end
        end
        repeat (items) random_word(read_pct);
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: spacing 100, target 256, empty table
        send_word(MODE_READ, 32'h0, 8'd0);
        send_word(MODE_READ, 32'hFFFF_FFFF, 8'd255);
        send_word(MODE_PROPOSE, 32'h0, 8'hFF);
        send_word(MODE_PROPOSE, 32'h0, 8'h00);
        send_word(MODE_PROPOSE, 32'hFFFF_FFFF, 8'h00);
        send_word(MODE_PROPOSE, 32'd99, 8'h00);
        send_word(MODE_PROPOSE, 32'd100, 8'h00);
        send_word(MODE_PROPOSE, 32'hFFFF_FF9B, 8'h00);
        send_word(MODE_PROPOSE, 32'hFFFF_FFFE, 8'h00);
        send_word(MODE_PROPOSE, 32'd150, 8'h00);
        send_word(MODE_READ, 32'h0, 8'd0);
        send_word(MODE_READ, 32'h0, 8'd3);
        send_word(MODE_READ, 32'h0, 8'd4);

        // zero spacing lets equal positions in
        settle();
        write_reg(CFG_MIN_SPACING, 32'h0);
        send_word(MODE_PROPOSE, 32'd100, 8'h00);
        send_word(MODE_PROPOSE, 32'hFFFF_FFFF, 8'h00);
        send_word(MODE_READ, 32'h0, 8'd2);
        send_word(MODE_READ, 32'h0, 8'd5);

        // spacing wider than any distance
        settle();
        write_reg(CFG_MIN_SPACING, 32'hFFFF_FFFF);
        send_word(MODE_PROPOSE, 32'h8000_0000, 8'h00);

        // target of zero, then target reached before the spacing check
        settle();
        write_reg(CFG_TARGET_COUNT, 32'h0);
        send_word(MODE_PROPOSE, 32'd12345, 8'h00);
        send_word(MODE_READ, 32'h0, 8'd0);
        settle();
        write_reg(CFG_MIN_SPACING, 32'd100);
        write_reg(CFG_TARGET_COUNT, sb.held_count);
        send_word(MODE_PROPOSE, 32'h4000_0000, 8'h00);

        run_phase($urandom_range(1, 1000), next_target(40), 220, 30, 1'b0);
        run_phase(32'h0, next_target(40), 220, 30, 1'b0);
        run_phase($urandom_range(32'h1_0000, 32'h100_0000), next_target(40), 220, 30, 1'b0);
        run_phase(32'hFFFF_FFFF, 9'd256, 200, 30, 1'b0);
        run_phase($urandom(), 9'd0, 150, 30, 1'b0);
        // target above capacity: fill the table, then keep pushing
        run_phase($urandom_range(1, 5000), 9'd511, 80, 30, 1'b1);
        run_phase(32'd100, 9'd256, 250, 60, 1'b0);

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
